[sv/rsti_pkg.sv]
// ----------------------------------------------------------------------------
// rsti_pkg - shared types and constants of the radix string parser
// Widths, character classes and the structs that pass between the front,
// the queue, the parser and the result stage.
// ----------------------------------------------------------------------------
package rsti_pkg;

   localparam int VALUE_BITS     = 32;
   localparam int OFFSET_BITS    = 16;
   localparam int POS_BITS       = OFFSET_BITS + 1;
   localparam int RADIX_BITS     = 6;
   localparam int CHAR_BITS      = 8;
   localparam int PROD_BITS      = VALUE_BITS + RADIX_BITS + 1;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 6;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE     = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNSIGNED = 1'b1;

   localparam logic [RADIX_BITS-1:0] NO_DIGIT   = '1;
   localparam logic [RADIX_BITS-1:0] BASE_AUTO  = 6'd0;
   localparam logic [RADIX_BITS-1:0] BASE_ONE   = 6'd1;
   localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
   localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;
   localparam logic [RADIX_BITS-1:0] BASE_RESET = RADIX_DEC;

   localparam logic [VALUE_BITS-1:0]  SIGN_HALF  = VALUE_BITS'(1) << (VALUE_BITS - 1);
   localparam logic [POS_BITS-1:0]    POS_CAP    = POS_BITS'(1) << OFFSET_BITS;
   localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

   typedef struct packed {
      logic                  is_space;
      logic                  is_plus;
      logic                  is_minus;
      logic                  is_zero;
      logic                  is_x;
      logic [RADIX_BITS-1:0] digit;
      logic                  last;
   } item_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic [RADIX_BITS-1:0] base_setting;
      logic                  unsigned_mode;
   } cfg_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] acc;
      logic                  negative;
      logic                  overflow;
      logic                  digit_seen;
      logic                  unsigned_mode;
      logic                  xwait;
      logic [POS_BITS-1:0]   pos;
   } fin_type;

endpackage

[sv/rsti_front.sv]
// ----------------------------------------------------------------------------
// rsti_front - character intake and classification
// Takes one character per cycle unless the queue is full, sorts it into
// whitespace, sign, prefix or digit class and pushes the item into the queue.
// ----------------------------------------------------------------------------
module rsti_front (
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [rsti_pkg::CHAR_BITS-1:0]     req_char_code,
   input  logic                               req_last_char,
   input  rsti_pkg::queue_status_type         q_status,
   output logic                               push,
   output rsti_pkg::item_type                 push_item
);

   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_TAB     = 8'd9;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_CR      = 8'd13;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_SPACE   = 8'd32;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_PLUS    = 8'd43;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_MINUS   = 8'd45;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_ZERO    = 8'd48;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_NINE    = 8'd57;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_UP_A    = 8'd65;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_UP_X    = 8'd88;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_UP_Z    = 8'd90;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_LO_A    = 8'd97;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_LO_X    = 8'd120;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] CH_LO_Z    = 8'd122;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] UP_OFFSET  = CH_UP_A - 8'd10;
   localparam logic [rsti_pkg::CHAR_BITS-1:0] LO_OFFSET  = CH_LO_A - 8'd10;

   logic [rsti_pkg::CHAR_BITS-1:0] rel;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      rel = '0;
      push_item.digit = rsti_pkg::NO_DIGIT;
      if (req_char_code >= CH_ZERO && req_char_code <= CH_NINE) begin
         rel = req_char_code - CH_ZERO;
         push_item.digit = rel[rsti_pkg::RADIX_BITS-1:0];
      end else if (req_char_code >= CH_UP_A && req_char_code <= CH_UP_Z) begin
         rel = req_char_code - UP_OFFSET;
         push_item.digit = rel[rsti_pkg::RADIX_BITS-1:0];
      end else if (req_char_code >= CH_LO_A && req_char_code <= CH_LO_Z) begin
         rel = req_char_code - LO_OFFSET;
         push_item.digit = rel[rsti_pkg::RADIX_BITS-1:0];
      end
      push_item.is_space = (req_char_code == CH_SPACE) ||
                           (req_char_code >= CH_TAB && req_char_code <= CH_CR);
      push_item.is_plus  = (req_char_code == CH_PLUS);
      push_item.is_minus = (req_char_code == CH_MINUS);
      push_item.is_zero  = (req_char_code == CH_ZERO);
      push_item.is_x     = (req_char_code == CH_LO_X) || (req_char_code == CH_UP_X);
      push_item.last     = req_last_char;
   end

endmodule

[sv/rsti_queue.sv]
// ----------------------------------------------------------------------------
// rsti_queue - two-entry item queue
// Decouples the classifier from the parser so that either side may stall.
// ----------------------------------------------------------------------------
module rsti_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  rsti_pkg::item_type         push_item,
   input  logic                       pop,
   output rsti_pkg::item_type         head_item,
   output rsti_pkg::queue_status_type q_status
);

   rsti_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head_item      = entry_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[sv/rsti_back.sv]
// ----------------------------------------------------------------------------
// rsti_back - parse state machine and accumulator
// Walks whitespace, sign and radix prefix, then folds digits into the
// accumulator with one multiply-add and a widened overflow compare.
// ----------------------------------------------------------------------------
module rsti_back (
   input  logic                       clock,
   input  logic                       reset,
   input  rsti_pkg::cfg_type          cfg,
   input  rsti_pkg::item_type         head_item,
   input  rsti_pkg::queue_status_type q_status,
   output logic                       pop,
   input  logic                       fin_ready,
   output logic                       fin_push,
   output rsti_pkg::fin_type          fin_data
);

   localparam logic [2:0] PH_WS     = 3'd0;
   localparam logic [2:0] PH_SIGNED = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_XWAIT  = 3'd3;
   localparam logic [2:0] PH_DIGITS = 3'd4;
   localparam logic [2:0] PH_DONE   = 3'd5;

   logic [2:0]                          phase_ff, phase_in;
   logic [rsti_pkg::VALUE_BITS-1:0]     acc_ff, acc_in;
   logic                                neg_ff, neg_in;
   logic [rsti_pkg::RADIX_BITS-1:0]     radix_ff, radix_in;
   logic                                ovf_ff, ovf_in;
   logic                                seen_ff, seen_in;
   logic [rsti_pkg::POS_BITS-1:0]       pos_ff, pos_in;

   logic                                start_path;
   logic                                bad_base;
   logic                                start_zero;
   logic [rsti_pkg::RADIX_BITS-1:0]     start_radix;
   logic [rsti_pkg::RADIX_BITS-1:0]     take_radix;
   logic [rsti_pkg::VALUE_BITS-1:0]     limit;
   logic [rsti_pkg::PROD_BITS-1:0]      prod;
   logic                                digit_ok;
   logic                                over;
   logic [rsti_pkg::POS_BITS-1:0]       pos_inc;

   // a final character needs room in the result stage, others never wait
   assign pop = !q_status.empty && (!head_item.last || fin_ready);

   assign start_path  = (phase_ff == PH_SIGNED) ||
                        ((phase_ff == PH_WS) && !head_item.is_space &&
                         !head_item.is_plus && !head_item.is_minus);
   assign bad_base    = (cfg.base_setting == rsti_pkg::BASE_ONE) ||
                        (cfg.base_setting > rsti_pkg::RADIX_MAX);
   assign start_zero  = head_item.is_zero &&
                        ((cfg.base_setting == rsti_pkg::BASE_AUTO) ||
                         (cfg.base_setting == rsti_pkg::RADIX_HEX));
   assign start_radix = (cfg.base_setting == rsti_pkg::BASE_AUTO) ?
                        rsti_pkg::RADIX_DEC : cfg.base_setting;
   assign take_radix  = start_path ? start_radix : radix_ff;

   always_comb begin
      if (cfg.unsigned_mode) begin
         limit = '1;
      end else if (neg_ff) begin
         limit = rsti_pkg::SIGN_HALF;
      end else begin
         limit = rsti_pkg::SIGN_HALF - rsti_pkg::VALUE_BITS'(1);
      end
   end

   assign prod     = rsti_pkg::PROD_BITS'(acc_ff) * rsti_pkg::PROD_BITS'(take_radix) +
                     rsti_pkg::PROD_BITS'(head_item.digit);
   assign digit_ok = (take_radix != '0) && (head_item.digit < take_radix);
   assign over     = ovf_ff || (prod > rsti_pkg::PROD_BITS'(limit));
   assign pos_inc  = (pos_ff < rsti_pkg::POS_CAP) ? pos_ff + 1'b1 : pos_ff;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      neg_in   = neg_ff;
      radix_in = radix_ff;
      ovf_in   = ovf_ff;
      seen_in  = seen_ff;
      pos_in   = pos_ff;

      // shared digit step, used by every phase that may take a digit
      if (start_path && bad_base) begin
         phase_in = PH_DONE;
      end else if (start_path && start_zero) begin
         seen_in  = 1'b1;
         acc_in   = '0;
         radix_in = (cfg.base_setting == rsti_pkg::BASE_AUTO) ?
                    rsti_pkg::RADIX_OCT : rsti_pkg::RADIX_HEX;
         phase_in = PH_ZERO;
         pos_in   = pos_inc;
      end else begin
         unique case (phase_ff)
            PH_WS: begin
               if (head_item.is_space) begin
                  pos_in = pos_inc;
               end else if (head_item.is_plus || head_item.is_minus) begin
                  neg_in   = head_item.is_minus;
                  phase_in = PH_SIGNED;
                  pos_in   = pos_inc;
               end else begin
                  radix_in = start_radix;
                  phase_in = PH_DIGITS;
               end
            end
            PH_SIGNED: begin
               radix_in = start_radix;
               phase_in = PH_DIGITS;
            end
            PH_ZERO: begin
               if (head_item.is_x) begin
                  radix_in = rsti_pkg::RADIX_HEX;
                  phase_in = PH_XWAIT;
                  pos_in   = pos_inc;
               end else begin
                  phase_in = PH_DIGITS;
               end
            end
            PH_XWAIT: begin
               if (head_item.digit < rsti_pkg::RADIX_HEX) begin
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_DONE;
                  if (pos_ff != '0) begin
                     pos_in = pos_ff - 1'b1;
                  end
               end
            end
            PH_DIGITS: begin
               phase_in = PH_DIGITS;
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase

         // take the digit, or stop on the first character that is not one
         if (phase_in == PH_DIGITS) begin
            if (!digit_ok) begin
               phase_in = PH_DONE;
            end else begin
               if (over) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = prod[rsti_pkg::VALUE_BITS-1:0];
               end
               seen_in = 1'b1;
               pos_in  = pos_inc;
            end
         end
      end
   end

   assign fin_push               = pop && head_item.last;
   assign fin_data.acc           = acc_in;
   assign fin_data.negative      = neg_in;
   assign fin_data.overflow      = ovf_in;
   assign fin_data.digit_seen    = seen_in;
   assign fin_data.unsigned_mode = cfg.unsigned_mode;
   assign fin_data.xwait         = (phase_in == PH_XWAIT);
   assign fin_data.pos           = pos_in;

   always_ff @(posedge clock) begin
      if (reset || fin_push) begin
         phase_ff <= PH_WS;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         radix_ff <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
         pos_ff   <= '0;
      end else if (pop) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         radix_ff <= radix_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

[sv/rsti_result.sv]
// ----------------------------------------------------------------------------
// rsti_result - result finishing and output register
// Holds the final parse state, applies sign, saturation and offset rules,
// and presents the result item on the output channel.
// ----------------------------------------------------------------------------
module rsti_result (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fin_push,
   input  rsti_pkg::fin_type                   fin_data,
   output logic                                fin_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [rsti_pkg::VALUE_BITS-1:0]     rsp_value,
   output logic                                rsp_out_of_range,
   output logic [rsti_pkg::OFFSET_BITS-1:0]    rsp_end_offset,
   output logic                                rsp_digits_found
);

   logic                                 fin_valid_ff;
   rsti_pkg::fin_type                    fin_ff;
   logic                                 out_load;

   logic                                 rsp_valid_ff;
   logic [rsti_pkg::VALUE_BITS-1:0]      value_ff, value_in;
   logic                                 range_ff, range_in;
   logic [rsti_pkg::OFFSET_BITS-1:0]     offset_ff, offset_in;
   logic                                 found_ff, found_in;
   logic [rsti_pkg::POS_BITS-1:0]        pos_adj;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign fin_ready = !fin_valid_ff || out_load;

   always_comb begin
      // a dangling "0x" does not count the x
      pos_adj = fin_ff.pos;
      if (fin_ff.xwait && fin_ff.pos != '0) begin
         pos_adj = fin_ff.pos - 1'b1;
      end

      if (!fin_ff.digit_seen) begin
         value_in = '0;
      end else if (fin_ff.overflow) begin
         if (fin_ff.unsigned_mode) begin
            value_in = '1;
         end else if (fin_ff.negative) begin
            value_in = rsti_pkg::SIGN_HALF;
         end else begin
            value_in = rsti_pkg::SIGN_HALF - rsti_pkg::VALUE_BITS'(1);
         end
      end else if (fin_ff.negative) begin
         value_in = ~fin_ff.acc + rsti_pkg::VALUE_BITS'(1);
      end else begin
         value_in = fin_ff.acc;
      end

      if (!fin_ff.digit_seen) begin
         offset_in = '0;
      end else if (pos_adj > rsti_pkg::POS_BITS'(rsti_pkg::OFFSET_MAX)) begin
         offset_in = rsti_pkg::OFFSET_MAX;
      end else begin
         offset_in = pos_adj[rsti_pkg::OFFSET_BITS-1:0];
      end

      range_in = fin_ff.digit_seen && fin_ff.overflow;
      found_in = fin_ff.digit_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (fin_ready) begin
            fin_valid_ff <= fin_push;
         end
         if (out_load) begin
            rsp_valid_ff <= fin_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fin_push && fin_ready) begin
         fin_ff <= fin_data;
      end
      if (out_load && fin_valid_ff) begin
         value_ff  <= value_in;
         range_ff  <= range_in;
         offset_ff <= offset_in;
         found_ff  <= found_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value        = value_ff;
   assign rsp_out_of_range = range_ff;
   assign rsp_end_offset   = offset_ff;
   assign rsp_digits_found = found_ff;

endmodule

[sv/radix_string_to_integer.sv]
// ----------------------------------------------------------------------------
// radix_string_to_integer - streaming string to integer parser
// Accepts one character per item and gives one result per string.
// ----------------------------------------------------------------------------
// The block takes one character per cycle while req_stall is low and returns
// one result item per string, on the item that carries last_char. Leading
// whitespace and a sign are skipped, a "0x" prefix or a leading zero picks
// the radix when base_setting asks for it, and digits up to base 36 are
// folded into a 32-bit value with saturation and a range flag. A final
// character passes through the classifier queue into the parser, then
// through the result stage's input and output registers, before its result
// is offered. The rate is set by the parser, which does one multiply-add
// and limit compare per character. Write base_setting and
// unsigned_mode only while no string is in flight; csr_ready is always high.
// ----------------------------------------------------------------------------
module radix_string_to_integer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [rsti_pkg::CHAR_BITS-1:0]         req_char_code,
   input  logic                                   req_last_char,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rsti_pkg::VALUE_BITS-1:0]        rsp_value,
   output logic                                   rsp_out_of_range,
   output logic [rsti_pkg::OFFSET_BITS-1:0]       rsp_end_offset,
   output logic                                   rsp_digits_found,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [rsti_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [rsti_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   logic [rsti_pkg::RADIX_BITS-1:0] base_ff;
   logic                            unsigned_ff;
   rsti_pkg::cfg_type               cfg;

   logic                            push;
   rsti_pkg::item_type              push_item;
   logic                            pop;
   rsti_pkg::item_type              head_item;
   rsti_pkg::queue_status_type      q_status;
   logic                            fin_push;
   logic                            fin_ready;
   rsti_pkg::fin_type               fin_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= rsti_pkg::BASE_RESET;
         unsigned_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rsti_pkg::CSR_BASE:     base_ff     <= csr_wdata[rsti_pkg::RADIX_BITS-1:0];
            rsti_pkg::CSR_UNSIGNED: unsigned_ff <= csr_wdata[0];
            default: begin
               base_ff <= base_ff;
            end
         endcase
      end
   end

   assign cfg.base_setting  = base_ff;
   assign cfg.unsigned_mode = unsigned_ff;

   rsti_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .req_last_char (req_last_char),
      .q_status      (q_status),
      .push          (push),
      .push_item     (push_item)
   );

   rsti_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   rsti_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head_item (head_item),
      .q_status  (q_status),
      .pop       (pop),
      .fin_ready (fin_ready),
      .fin_push  (fin_push),
      .fin_data  (fin_data)
   );

   rsti_result u_result (
      .clock            (clock),
      .reset            (reset),
      .fin_push         (fin_push),
      .fin_data         (fin_data),
      .fin_ready        (fin_ready),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_digits_found (rsp_digits_found)
   );

   // an accepted item is held in the queue at the next edge
   a_push_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_status.empty)
      else $error("accepted item missing from queue");

   // the parser never takes an item from an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   // a string without digits reports zero throughout
   a_no_digit_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_digits_found) |->
         (rsp_value == '0) && (rsp_end_offset == '0) && !rsp_out_of_range)
      else $error("result without digits is not zero");

   // a range error needs at least one digit
   a_range_needs_digit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> rsp_digits_found)
      else $error("range flag without digits");

endmodule

[bench/radix_string_to_integer_tb.sv]
// ----------------------------------------------------------------------------
// radix_string_to_integer_tb - self-checking bench for the string parser
// Streams characters into the parser under random idling on both sides,
// predicts each string's value, range flag, end offset and digit flag with
// its own scanner, and compares every result in order. A short table of
// hand-picked strings comes first, then random well-formed numbers mixed
// with noise across several radix and sign-mode settings.
// ----------------------------------------------------------------------------
module radix_string_to_integer_tb;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned PHASE_CHARS  = 136;
   localparam int unsigned SETTLE_GAP   = 6;
   localparam int unsigned HOLD_CYCLES  = 200;
   localparam int unsigned REPORT_LIMIT = 200;

   localparam logic [2:0] PH_SPACE     = 3'd0;
   localparam logic [2:0] PH_SIGN      = 3'd1;
   localparam logic [2:0] PH_LEAD_ZERO = 3'd2;
   localparam logic [2:0] PH_PREFIX    = 3'd3;
   localparam logic [2:0] PH_DIGIT     = 3'd4;
   localparam logic [2:0] PH_STOP      = 3'd5;

   typedef struct packed {
      logic [rsti_pkg::VALUE_BITS-1:0]  value;
      logic                             out_of_range;
      logic [rsti_pkg::OFFSET_BITS-1:0] end_offset;
      logic                             digits_found;
   } parse_result_type;

   typedef struct packed {
      logic             given;
      parse_result_type result;
   } known_result_type;

   typedef struct {
      logic [rsti_pkg::RADIX_BITS-1:0] base;
      logic                            uns;
      string                           text;
      logic                            given;
      parse_result_type                result;
   } sample_row_type;

   logic                                    clock = 1'b0;
   logic                                    reset = 1'b1;
   logic                                    req_valid = 1'b0;
   logic                                    req_stall;
   logic [rsti_pkg::CHAR_BITS-1:0]          req_char_code = '0;
   logic                                    req_last_char = 1'b0;
   logic                                    rsp_valid;
   logic                                    rsp_stall = 1'b0;
   logic [rsti_pkg::VALUE_BITS-1:0]         rsp_value;
   logic                                    rsp_out_of_range;
   logic [rsti_pkg::OFFSET_BITS-1:0]        rsp_end_offset;
   logic                                    rsp_digits_found;
   logic                                    csr_valid = 1'b0;
   logic                                    csr_ready;
   logic [rsti_pkg::CSR_INDEX_BITS-1:0]     csr_index = rsti_pkg::CSR_BASE;
   logic [rsti_pkg::CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // shadow of the block's registers, the scanner's own state
   logic [rsti_pkg::RADIX_BITS-1:0]  cfg_base = rsti_pkg::BASE_RESET;
   logic                             cfg_uns = 1'b0;
   logic [2:0]                       scan_phase = PH_SPACE;
   logic [rsti_pkg::VALUE_BITS-1:0]  scan_acc = '0;
   logic                             scan_neg = 1'b0;
   logic [rsti_pkg::RADIX_BITS-1:0]  scan_radix = '0;
   logic                             scan_ovf = 1'b0;
   logic                             scan_seen = 1'b0;
   logic [rsti_pkg::POS_BITS-1:0]    scan_pos = '0;

   parse_result_type awaited_numbers [$];
   known_result_type known_results [$];

   logic        quiet = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_taken = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned failures = 0;
   int unsigned chars_taken = 0;
   int unsigned strings_checked = 0;
   int unsigned saturated_count = 0;
   int unsigned empty_count = 0;
   int unsigned settings_applied = 0;

   radix_string_to_integer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_digits_found (rsp_digits_found),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- scanner

   function automatic logic is_space(logic [rsti_pkg::CHAR_BITS-1:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [rsti_pkg::RADIX_BITS-1:0] digit_value(
         logic [rsti_pkg::CHAR_BITS-1:0] c);
      if (c >= "0" && c <= "9") return rsti_pkg::RADIX_BITS'(c - "0");
      if (c >= "A" && c <= "Z") return rsti_pkg::RADIX_BITS'(c - "A" + 10);
      if (c >= "a" && c <= "z") return rsti_pkg::RADIX_BITS'(c - "a" + 10);
      return rsti_pkg::NO_DIGIT;
   endfunction

   function automatic void bump_pos();
      if (scan_pos < rsti_pkg::POS_CAP) scan_pos++;
   endfunction

   function automatic void clear_scan();
      scan_phase = PH_SPACE;
      scan_acc   = '0;
      scan_neg   = 1'b0;
      scan_radix = '0;
      scan_ovf   = 1'b0;
      scan_seen  = 1'b0;
      scan_pos   = '0;
   endfunction

   function automatic void fold_digit(logic [rsti_pkg::CHAR_BITS-1:0] c);
      logic [rsti_pkg::RADIX_BITS-1:0] d;
      longint unsigned                 lim, cut, cut_rem;
      d = digit_value(c);
      if (scan_radix == 0 || d >= scan_radix) begin
         scan_phase = PH_STOP;
         return;
      end
      if (cfg_uns) lim = 64'hFFFF_FFFF;
      else lim = scan_neg ? 64'(rsti_pkg::SIGN_HALF) : 64'(rsti_pkg::SIGN_HALF) - 1;
      cut     = lim / scan_radix;
      cut_rem = lim % scan_radix;
      if (scan_ovf || scan_acc > cut || (scan_acc == cut && d > cut_rem))
         scan_ovf = 1'b1;
      else
         scan_acc = rsti_pkg::VALUE_BITS'(64'(scan_acc) * scan_radix + d);
      scan_seen  = 1'b1;
      scan_phase = PH_DIGIT;
      bump_pos();
   endfunction

   // the radix is chosen here, at the first character after space and sign; an x after a leading zero makes it hex
   function automatic void begin_number(logic [rsti_pkg::CHAR_BITS-1:0] c);
      if (cfg_base == rsti_pkg::BASE_ONE || cfg_base > rsti_pkg::RADIX_MAX) begin
         scan_phase = PH_STOP;
         return;
      end
      if (c == "0" && (cfg_base == rsti_pkg::BASE_AUTO || cfg_base == rsti_pkg::RADIX_HEX)) begin
         scan_seen  = 1'b1;
         scan_acc   = '0;
         scan_radix = (cfg_base == rsti_pkg::BASE_AUTO) ? rsti_pkg::RADIX_OCT :
                                                          rsti_pkg::RADIX_HEX;
         scan_phase = PH_LEAD_ZERO;
         bump_pos();
         return;
      end
      scan_radix = (cfg_base == rsti_pkg::BASE_AUTO) ? rsti_pkg::RADIX_DEC : cfg_base;
      fold_digit(c);
   endfunction

   function automatic void scan_char(input logic [rsti_pkg::CHAR_BITS-1:0] c,
                                     input logic last,
                                     output logic produced, output parse_result_type r);
      logic [rsti_pkg::POS_BITS-1:0] endp;
      produced = 1'b0;
      r = '0;
      unique case (scan_phase)
         PH_SPACE: begin
            if (is_space(c)) begin
               bump_pos();
            end else if (c == "+" || c == "-") begin
               scan_neg   = (c == "-");
               scan_phase = PH_SIGN;
               bump_pos();
            end else begin
               begin_number(c);
            end
         end
         PH_SIGN: begin_number(c);
         PH_LEAD_ZERO: begin
            if (c == "x" || c == "X") begin
               scan_radix = rsti_pkg::RADIX_HEX;
               scan_phase = PH_PREFIX;
               bump_pos();
            end else begin
               fold_digit(c);
            end
         end
         PH_PREFIX: begin
            // a bare prefix converts the zero only: step back onto the x
            if (digit_value(c) < rsti_pkg::RADIX_HEX) begin
               fold_digit(c);
            end else begin
               scan_phase = PH_STOP;
               if (scan_pos != 0) scan_pos--;
            end
         end
         PH_DIGIT: fold_digit(c);
         default: ;
      endcase
      if (!last) return;

      if (scan_phase == PH_PREFIX && scan_pos != 0) scan_pos--;
      endp = (scan_pos > rsti_pkg::OFFSET_MAX) ?
             rsti_pkg::POS_BITS'(rsti_pkg::OFFSET_MAX) : scan_pos;
      produced       = 1'b1;
      r.digits_found = scan_seen;
      r.out_of_range = scan_seen && scan_ovf;
      r.end_offset   = scan_seen ? endp[rsti_pkg::OFFSET_BITS-1:0] : '0;
      if (!scan_seen)    r.value = '0;
      else if (scan_ovf) r.value = cfg_uns ? '1 :
                                   (scan_neg ? rsti_pkg::SIGN_HALF : rsti_pkg::SIGN_HALF - 1);
      else               r.value = scan_neg ? -scan_acc : scan_acc;
      clear_scan();
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic check_field(input string field,
                              input logic [rsti_pkg::VALUE_BITS-1:0] want,
                              input logic [rsti_pkg::VALUE_BITS-1:0] got);
      if (want !== got) begin
         // keep the log readable on a badly broken block
         if (failures < REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : watch
      parse_result_type want, got;
      logic             produced;
      known_result_type known;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            chars_taken++;
            scan_char(req_char_code, req_last_char, produced, want);
            if (produced) begin
               if (known_results.size() != 0) begin
                  known = known_results.pop_front();
                  if (known.given) want = known.result;
               end
               awaited_numbers.push_back(want);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_value, rsp_out_of_range, rsp_end_offset, rsp_digits_found};
            if (awaited_numbers.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t: result with none awaited, actual value %0h offset %0d",
                           $time, got.value, got.end_offset);
               failures++;
            end else begin
               want = awaited_numbers.pop_front();
               check_field("value", want.value, got.value);
               check_field("out_of_range", want.out_of_range, got.out_of_range);
               check_field("end_offset", want.end_offset, got.end_offset);
               check_field("digits_found", want.digits_found, got.digits_found);
               strings_checked++;
               if (want.out_of_range) saturated_count++;
               if (!want.digits_found) empty_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: run limit reached, %0d results still awaited",
                  $time, awaited_numbers.size());
         $display("[radix_string_to_integer] ERROR");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_request && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(0, 99) < 24);
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(input logic [rsti_pkg::CHAR_BITS-1:0] c, input logic last);
      while (!quiet && $urandom_range(0, 99) < 24) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= c;
      req_last_char <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_string(ref logic [rsti_pkg::CHAR_BITS-1:0] s [$]);
      for (int k = 0; k < s.size(); k++) send_item(s[k], k == s.size() - 1);
   endtask

   // drop valid and wait out every awaited result before touching registers
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_numbers.size() != 0) @(posedge clock);
      repeat (SETTLE_GAP) @(posedge clock);
   endtask

   task automatic csr_put(input logic [rsti_pkg::CSR_INDEX_BITS-1:0] idx,
                          input logic [rsti_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == rsti_pkg::CSR_BASE) cfg_base = data;
      else cfg_uns = data[0];
   endtask

   task automatic apply_settings(input logic [rsti_pkg::RADIX_BITS-1:0] base,
                                 input logic uns);
      csr_put(rsti_pkg::CSR_BASE, base);
      csr_put(rsti_pkg::CSR_UNSIGNED, rsti_pkg::CSR_DATA_BITS'(uns));
      csr_valid <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [rsti_pkg::CHAR_BITS-1:0] digit_char(int unsigned d);
      if (d < 10) return rsti_pkg::CHAR_BITS'("0" + d);
      return rsti_pkg::CHAR_BITS'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
   endfunction

   // mostly well-formed numbers in the current radix, some noise
   task automatic build_string(ref logic [rsti_pkg::CHAR_BITS-1:0] s [$]);
      logic [rsti_pkg::CHAR_BITS-1:0]  ws_set [6];
      logic [rsti_pkg::RADIX_BITS-1:0] digs [$];
      int unsigned                     pick, count, radix;
      longint unsigned                 num;
      ws_set = '{8'd32, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13};
      s.delete();
      if ($urandom_range(0, 99) < 10) begin
         repeat ($urandom_range(1, 6))
            s.push_back(rsti_pkg::CHAR_BITS'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(0, 3)) s.push_back(ws_set[$urandom_range(0, 5)]);
      case ($urandom_range(0, 2))
         1: s.push_back("+");
         2: s.push_back("-");
         default: ;
      endcase
      radix = (cfg_base >= 2 && cfg_base <= rsti_pkg::RADIX_MAX) ? cfg_base :
                                                                  rsti_pkg::RADIX_DEC;
      if (cfg_base == rsti_pkg::BASE_AUTO || cfg_base == rsti_pkg::RADIX_HEX) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            s.push_back("0");
            s.push_back($urandom_range(0, 1) ? "x" : "X");
            radix = rsti_pkg::RADIX_HEX;
         end else if (cfg_base == rsti_pkg::BASE_AUTO && pick < 70) begin
            s.push_back("0");
            radix = rsti_pkg::RADIX_OCT;
         end
      end
      if ($urandom_range(0, 99) < 20) begin
         // values on either side of the limits, written out in the radix
         case ($urandom_range(0, 6))
            0: num = 64'h7FFF_FFFF;
            1: num = 64'h8000_0000;
            2: num = 64'h8000_0001;
            3: num = 64'hFFFF_FFFF;
            4: num = 64'h1_0000_0000;
            5: num = 64'($urandom);
            default: num = (64'($urandom_range(0, 15)) << 32) | 64'($urandom);
         endcase
         do begin
            digs.push_front(rsti_pkg::RADIX_BITS'(num % radix));
            num = num / radix;
         end while (num != 0);
         foreach (digs[k]) s.push_back(digit_char(digs[k]));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 5)       count = 0;
         else if (pick < 70) count = $urandom_range(1, 6);
         else if (pick < 95) count = $urandom_range(7, 14);
         else                count = $urandom_range(15, 40);
         repeat (count) begin
            if ($urandom_range(0, 99) < 92)
               s.push_back(digit_char($urandom_range(0, radix - 1)));
            else
               s.push_back(rsti_pkg::CHAR_BITS'($urandom_range(0, 255)));
         end
      end
      repeat ($urandom_range(0, 2))
         s.push_back(rsti_pkg::CHAR_BITS'($urandom_range(0, 255)));
      if (s.size() == 0) s.push_back("0");
   endtask

   initial begin
      sample_row_type                  plan [12];
      logic [rsti_pkg::CHAR_BITS-1:0]  line [$];
      logic [rsti_pkg::RADIX_BITS-1:0] base_plan [8];
      int unsigned                     phase_chars;
      logic                            hold_done;

      plan = '{
         '{rsti_pkg::RADIX_DEC, 1'b0, "7",       1'b1, '{32'd7,         1'b0, 16'd1, 1'b1}},
         '{rsti_pkg::RADIX_DEC, 1'b0, "z",       1'b1, '{32'd0,         1'b0, 16'd0, 1'b0}},
         '{rsti_pkg::RADIX_DEC, 1'b0, "\t-5",    1'b1, '{32'hFFFF_FFFB, 1'b0, 16'd3, 1'b1}},
         '{rsti_pkg::RADIX_DEC, 1'b0, "\377",    1'b1, '{32'd0,         1'b0, 16'd0, 1'b0}},
         '{rsti_pkg::RADIX_DEC, 1'b1, "1 ",      1'b0, '0},
         '{rsti_pkg::BASE_ONE,  1'b0, "5",       1'b1, '{32'd0,         1'b0, 16'd0, 1'b0}},
         '{6'd63,               1'b0, "5",       1'b1, '{32'd0,         1'b0, 16'd0, 1'b0}},
         '{rsti_pkg::RADIX_HEX, 1'b0, "0xg",     1'b1, '{32'd0,         1'b0, 16'd1, 1'b1}},
         '{rsti_pkg::BASE_AUTO, 1'b0, "017",     1'b1, '{32'd15,        1'b0, 16'd3, 1'b1}},
         '{rsti_pkg::BASE_AUTO, 1'b1, "0Xf",     1'b0, '0},
         '{rsti_pkg::RADIX_MAX, 1'b0, "-zzzzzz", 1'b1, '{32'h8000_0000, 1'b1, 16'd7, 1'b1}},
         '{6'd2,                1'b1, "-1",      1'b1, '{32'hFFFF_FFFF, 1'b0, 16'd2, 1'b1}}
      };
      base_plan = '{rsti_pkg::BASE_AUTO, rsti_pkg::RADIX_HEX, rsti_pkg::RADIX_DEC,
                    rsti_pkg::RADIX_MAX, 6'd2, rsti_pkg::RADIX_OCT, rsti_pkg::BASE_ONE,
                    rsti_pkg::RADIX_BITS'($urandom_range(0, 63))};
      hold_done = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].base !== cfg_base || plan[i].uns !== cfg_uns) begin
            settle();
            apply_settings(plan[i].base, plan[i].uns);
         end
         known_results.push_back('{plan[i].given, plan[i].result});
         for (int j = 0; j < plan[i].text.len(); j++)
            send_item(plan[i].text[j], j == plan[i].text.len() - 1);
      end

      for (int ph = 0; ph < 8; ph++) begin
         settle();
         apply_settings(base_plan[ph], 1'(ph % 2));
         quiet = (ph == 3);
         phase_chars = 0;
         while (phase_chars < PHASE_CHARS) begin
            build_string(line);
            send_string(line);
            phase_chars += line.size();
            // stall the result side for a long stretch while items keep coming
            if (ph == 2 && !hold_done && phase_chars > 30) begin
               hold_request <= 1'b1;
               hold_done = 1'b1;
            end
         end
      end
      quiet = 1'b0;
      settle();

      $display("covered %0d characters in %0d strings over %0d register settings",
               chars_taken, strings_checked, settings_applied);
      $display("%0d strings saturated at a limit, %0d gave no digit, %0d failures",
               saturated_count, empty_count, failures);
      if (failures == 0) begin
         $display("[radix_string_to_integer] OK");
      end else begin
         $display("[radix_string_to_integer] ERROR");
      end
      $finish;
   end

endmodule
